FILE: rtl/lz4_block_decompressor_macros.svh
// Assertion macros for the LZ4 block decompressor.
// Included by the RTL modules that carry concurrent assertions; no other dependencies.
`ifndef LZ4_BLOCK_DECOMPRESSOR_MACROS_SVH
`define LZ4_BLOCK_DECOMPRESSOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LZ4D_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LZ4D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/lz4d_pkg.sv
// Shared types and constants for the LZ4 block decompressor.
// Has no dependencies; imported by lz4_block_decompressor.
`timescale 1ns / 1ps

package lz4d_pkg;

	// Default width of the length and byte counters.
	localparam int unsigned LZ4D_COUNT_BITS = 24;

	// The history window is fixed at 64 KiB.
	localparam int unsigned HIST_AW = 16;

	localparam int unsigned CAP_W = 24;
	localparam int unsigned OUT_CNT_W = 24;
	localparam logic [CAP_W-1:0] CAP_RESET = 24'd65536;

	// Result queue depth; must hold the worst case of two words in flight plus two queued.
	localparam int unsigned RQ_DEPTH = 4;
	localparam int unsigned RQ_AW = $clog2(RQ_DEPTH);

	localparam logic [3:0] NIB_EXT = 4'hF;
	localparam logic [7:0] BYTE_EXT = 8'hFF;
	localparam int unsigned MIN_MATCH = 4;

	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;

	localparam logic [2:0] ERR_TRUNC = 3'd0;
	localparam logic [2:0] ERR_ZERO_OFF = 3'd1;
	localparam logic [2:0] ERR_FAR_OFF = 3'd2;
	localparam logic [2:0] ERR_CAPACITY = 3'd3;
	localparam logic [2:0] ERR_IN_COPY = 3'd4;

	typedef enum logic [2:0] {
		PH_TOKEN,
		PH_LITEXT,
		PH_LIT,
		PH_OFFLO,
		PH_OFFHI,
		PH_MEXT,
		PH_COPY,
		PH_DRAIN
	} phase_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
		logic       last_byte;
	} req_item_t;

	typedef struct packed {
		logic [1:0]           kind;
		logic [7:0]           out_byte;
		logic [OUT_CNT_W-1:0] out_count;
		logic [2:0]           error_code;
	} rsp_item_t;

endpackage

FILE: rtl/lz4_block_decompressor.sv
// LZ4 block decompressor: token parser, 64 KiB history window and result queue.
// Depends on lz4d_pkg and the assertion macros in lz4_block_decompressor_macros.svh.
`timescale 1ns / 1ps

// One request word per cycle: a compressed byte or a copy tick. The parser updates its state
// as the word is taken; the history window is read on that same edge, so each word reaches a
// register stage where its output byte is resolved and written back to the history, and then
// enters a four-word result queue from which rsp is driven, so no result bypasses the queue.
// Sustained throughput is one request per cycle as long as rsp is drained; a request
// that yields two results (the last literal with its block-done or error word) occupies two
// queue slots, and req_ready drops while the queue cannot absorb another two-result request.
// The history is not cleared at reset: copies only read bytes written earlier in the block.
module lz4_block_decompressor
	import lz4d_pkg::*;
#(
	parameter int unsigned COUNT_BITS = LZ4D_COUNT_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_item_t        req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_item_t        rsp,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata
);

`include "lz4_block_decompressor_macros.svh"

	localparam int unsigned CNT_W = COUNT_BITS;
	localparam int unsigned CMP_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam int unsigned RQ_CW = RQ_AW + 1;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
	endfunction

	function automatic rsp_item_t mk_word(input logic [1:0] kind, input logic [7:0] b,
			input logic [CNT_W-1:0] cnt, input logic [2:0] code);
		rsp_item_t w;
		w.kind = kind;
		w.out_byte = b;
		w.out_count = OUT_CNT_W'(cnt);
		w.error_code = code;
		return w;
	endfunction

	// Configuration and parser state.
	logic [CAP_W-1:0]   cap_q;
	phase_t             phase_q;
	logic [CNT_W-1:0]   lit_q;
	logic [CNT_W-1:0]   ml_q;
	logic [15:0]        off_q;
	logic [CNT_W-1:0]   bw_q;

	// History window.
	logic [7:0]         hist_mem [2**HIST_AW];

	// Stage 1: results of the word taken on the last edge.
	logic [1:0]         n_s1;
	rsp_item_t          res_s1 [2];
	logic               mem_s1;
	logic               wr_s1;
	logic [HIST_AW-1:0] waddr_s1;
	logic [7:0]         rd_data_s1;
	logic               byp_hit_s1;
	logic [7:0]         byp_data_s1;
	logic [7:0]         byte_s1;

	// Result queue.
	rsp_item_t          rq_q [RQ_DEPTH];
	logic [RQ_AW-1:0]   rq_wp_q;
	logic [RQ_AW-1:0]   rq_rp_q;
	logic [RQ_CW-1:0]   rq_cnt_q;

	logic               acc;
	logic               pop;
	logic [CMP_W-1:0]   cap_eff;
	logic [HIST_AW-1:0] raddr;

	phase_t             nxt_phase;
	logic [CNT_W-1:0]   nxt_lit;
	logic [CNT_W-1:0]   nxt_ml;
	logic [15:0]        nxt_off;
	logic [CNT_W-1:0]   nxt_bw;
	logic [1:0]         res_n;
	rsp_item_t          res [2];
	logic               use_mem;
	logic               wr;
	logic               chk_lit;
	logic               chk_match;
	logic               do_new;
	logic [CNT_W-1:0]   lit_len;
	logic [CNT_W-1:0]   m_len;
	logic [CNT_W-1:0]   ml_full;
	logic [15:0]        off_new;
	logic [CNT_W-1:0]   bw_inc;

	assign acc = req_valid && req_ready;
	assign pop = rsp_valid && rsp_ready;
	// Room is reserved for the word in stage 1 plus a worst-case incoming word.
	assign req_ready = (rq_cnt_q + RQ_CW'(n_s1)) <= RQ_CW'(RQ_DEPTH - 2);

	always_comb begin
		if (CMP_W'(cap_q) < CMP_W'(CNT_MAX)) begin
			cap_eff = CMP_W'(cap_q);
		end else begin
			cap_eff = CMP_W'(CNT_MAX);
		end
	end

	assign raddr = bw_q[HIST_AW-1:0] - off_q[HIST_AW-1:0];

	always_comb begin
		nxt_phase = phase_q;
		nxt_lit = lit_q;
		nxt_ml = ml_q;
		nxt_off = off_q;
		nxt_bw = bw_q;
		res_n = 2'd0;
		res[0] = '0;
		res[1] = '0;
		use_mem = 1'b0;
		wr = 1'b0;
		chk_lit = 1'b0;
		chk_match = 1'b0;
		do_new = 1'b0;
		lit_len = '0;
		m_len = '0;
		ml_full = '0;
		off_new = '0;
		bw_inc = sat_add(bw_q, CNT_W'(1));

		if (acc) begin
			if (req.req_type == REQ_TICK) begin
				// Ticks outside a copy are ignored.
				if (phase_q == PH_COPY) begin
					res[0] = mk_word(KIND_BYTE, 8'h00, '0, ERR_TRUNC);
					res_n = 2'd1;
					use_mem = 1'b1;
					wr = 1'b1;
					nxt_bw = bw_inc;
					nxt_ml = ml_q - CNT_W'(1);
					if (ml_q == CNT_W'(1)) begin
						nxt_phase = PH_TOKEN;
					end
				end
			end else begin
				unique case (phase_q)
					PH_TOKEN: begin
						nxt_lit = CNT_W'(req.data_byte[7:4]);
						nxt_ml = CNT_W'(req.data_byte[3:0]);
						if (req.data_byte[7:4] == NIB_EXT) begin
							if (req.last_byte) begin
								res[0] = mk_word(KIND_ERR, 8'h00, '0, ERR_TRUNC);
								res_n = 2'd1;
								do_new = 1'b1;
							end else begin
								nxt_phase = PH_LITEXT;
							end
						end else begin
							lit_len = CNT_W'(req.data_byte[7:4]);
							chk_lit = 1'b1;
						end
					end
					PH_LITEXT: begin
						lit_len = sat_add(lit_q, CNT_W'(req.data_byte));
						nxt_lit = lit_len;
						if (req.data_byte == BYTE_EXT) begin
							if (req.last_byte) begin
								res[0] = mk_word(KIND_ERR, 8'h00, '0, ERR_TRUNC);
								res_n = 2'd1;
								do_new = 1'b1;
							end
						end else begin
							chk_lit = 1'b1;
						end
					end
					PH_LIT: begin
						res[0] = mk_word(KIND_BYTE, req.data_byte, '0, ERR_TRUNC);
						res_n = 2'd1;
						wr = 1'b1;
						nxt_bw = bw_inc;
						nxt_lit = lit_q - CNT_W'(1);
						if (lit_q == CNT_W'(1)) begin
							if (req.last_byte) begin
								res[1] = mk_word(KIND_DONE, 8'h00, bw_inc, ERR_TRUNC);
								res_n = 2'd2;
								do_new = 1'b1;
							end else begin
								nxt_phase = PH_OFFLO;
							end
						end else if (req.last_byte) begin
							res[1] = mk_word(KIND_ERR, 8'h00, '0, ERR_TRUNC);
							res_n = 2'd2;
							do_new = 1'b1;
						end
					end
					PH_OFFLO: begin
						if (req.last_byte) begin
							res[0] = mk_word(KIND_ERR, 8'h00, '0, ERR_TRUNC);
							res_n = 2'd1;
							do_new = 1'b1;
						end else begin
							nxt_off = {8'h00, req.data_byte};
							nxt_phase = PH_OFFHI;
						end
					end
					PH_OFFHI: begin
						off_new = {req.data_byte, off_q[7:0]};
						nxt_off = off_new;
						if (off_new == 16'h0000) begin
							res[0] = mk_word(KIND_ERR, 8'h00, '0, ERR_ZERO_OFF);
							res_n = 2'd1;
							do_new = req.last_byte;
							nxt_phase = PH_DRAIN;
						end else if (CNT_W'(off_new) > bw_q) begin
							res[0] = mk_word(KIND_ERR, 8'h00, '0, ERR_FAR_OFF);
							res_n = 2'd1;
							do_new = req.last_byte;
							nxt_phase = PH_DRAIN;
						end else if (req.last_byte) begin
							res[0] = mk_word(KIND_ERR, 8'h00, '0, ERR_TRUNC);
							res_n = 2'd1;
							do_new = 1'b1;
						end else if (ml_q == CNT_W'(NIB_EXT)) begin
							nxt_phase = PH_MEXT;
						end else begin
							m_len = ml_q;
							chk_match = 1'b1;
						end
					end
					PH_MEXT: begin
						if (req.last_byte) begin
							res[0] = mk_word(KIND_ERR, 8'h00, '0, ERR_TRUNC);
							res_n = 2'd1;
							do_new = 1'b1;
						end else begin
							m_len = sat_add(ml_q, CNT_W'(req.data_byte));
							nxt_ml = m_len;
							chk_match = req.data_byte != BYTE_EXT;
						end
					end
					PH_COPY: begin
						res[0] = mk_word(KIND_ERR, 8'h00, '0, ERR_IN_COPY);
						res_n = 2'd1;
						do_new = req.last_byte;
						nxt_phase = PH_DRAIN;
					end
					PH_DRAIN: begin
						do_new = req.last_byte;
					end
					default: begin
						nxt_phase = PH_DRAIN;
					end
				endcase

				// Literal run length is known.
				if (chk_lit) begin
					if (lit_len == '0) begin
						if (req.last_byte) begin
							res[0] = mk_word(KIND_DONE, 8'h00, bw_q, ERR_TRUNC);
							res_n = 2'd1;
							do_new = 1'b1;
						end else begin
							nxt_phase = PH_OFFLO;
						end
					end else if (req.last_byte) begin
						res[0] = mk_word(KIND_ERR, 8'h00, '0, ERR_TRUNC);
						res_n = 2'd1;
						do_new = 1'b1;
					end else if ((CMP_W'(bw_q) + CMP_W'(lit_len)) > cap_eff) begin
						res[0] = mk_word(KIND_ERR, 8'h00, '0, ERR_CAPACITY);
						res_n = 2'd1;
						nxt_phase = PH_DRAIN;
					end else begin
						nxt_phase = PH_LIT;
					end
				end

				// Match length is known; the minimum match is added here.
				if (chk_match) begin
					ml_full = sat_add(m_len, CNT_W'(MIN_MATCH));
					nxt_ml = ml_full;
					if ((CMP_W'(bw_q) + CMP_W'(ml_full)) > cap_eff) begin
						res[0] = mk_word(KIND_ERR, 8'h00, '0, ERR_CAPACITY);
						res_n = 2'd1;
						nxt_phase = PH_DRAIN;
					end else begin
						nxt_phase = PH_COPY;
					end
				end
			end

			if (do_new) begin
				nxt_phase = PH_TOKEN;
				nxt_lit = '0;
				nxt_ml = '0;
				nxt_off = '0;
				nxt_bw = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			phase_q <= PH_TOKEN;
			lit_q <= '0;
			ml_q <= '0;
			off_q <= '0;
			bw_q <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			phase_q <= nxt_phase;
			lit_q <= nxt_lit;
			ml_q <= nxt_ml;
			off_q <= nxt_off;
			bw_q <= nxt_bw;
		end
	end

	// The word in stage 1 writes its byte on the same edge that a new tick reads the window,
	// so a read of that address takes the byte from the bypass instead.
	assign byte_s1 = mem_s1 ? (byp_hit_s1 ? byp_data_s1 : rd_data_s1) : res_s1[0].out_byte;

	always_ff @(posedge clk) begin
		rd_data_s1 <= hist_mem[raddr];
		if (wr_s1) begin
			hist_mem[waddr_s1] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_s1 <= '0;
			wr_s1 <= 1'b0;
		end else begin
			n_s1 <= res_n;
			wr_s1 <= wr;
		end
	end

	always_ff @(posedge clk) begin
		res_s1[0] <= res[0];
		res_s1[1] <= res[1];
		mem_s1 <= use_mem;
		waddr_s1 <= bw_q[HIST_AW-1:0];
		byp_hit_s1 <= wr_s1 && (waddr_s1 == raddr);
		byp_data_s1 <= byte_s1;
	end

	// Result queue: up to two pushes and one pop per cycle.
	always_ff @(posedge clk) begin
		if (n_s1 != 2'd0) begin
			rq_q[rq_wp_q] <= '{kind: res_s1[0].kind, out_byte: byte_s1,
				out_count: res_s1[0].out_count, error_code: res_s1[0].error_code};
		end
		if (n_s1 == 2'd2) begin
			rq_q[rq_wp_q + RQ_AW'(1)] <= res_s1[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wp_q <= '0;
			rq_rp_q <= '0;
			rq_cnt_q <= '0;
		end else begin
			rq_wp_q <= rq_wp_q + RQ_AW'(n_s1);
			if (pop) begin
				rq_rp_q <= rq_rp_q + RQ_AW'(1);
			end
			rq_cnt_q <= rq_cnt_q + RQ_CW'(n_s1) - RQ_CW'(pop);
		end
	end

	assign rsp_valid = rq_cnt_q != '0;
	assign rsp = rq_q[rq_rp_q];

	`LZ4D_ASSERT_SAME(a_rq_no_overflow, clk, arst_n, 1'b1,
		(rq_cnt_q + RQ_CW'(n_s1)) <= RQ_CW'(RQ_DEPTH), "result queue would overflow")
	`LZ4D_ASSERT_SAME(a_copy_len_nonzero, clk, arst_n, phase_q == PH_COPY, ml_q != '0,
		"copy phase entered with no match bytes left")
	`LZ4D_ASSERT_NEXT(a_tick_goes_to_window, clk, arst_n, use_mem, mem_s1 && wr_s1 && (n_s1 == 2'd1),
		"copy byte did not reach the window write stage")

endmodule
